FILE: hw/rtl/mptk_pkg.sv
// Shared widths, reset constants and the token type for the profit chain.
// Used by mptk_cell and max_profit_k_transactions_top; depends on nothing.
package mptk_pkg;

    localparam int PRICE_W       = 16;
    localparam int PROFIT_W      = 26;
    localparam int HOLD_W        = 28;
    localparam int FREE_W        = 27;
    localparam int K_W           = 5;
    localparam int MAX_TRANS_DEF = 16;
    localparam int K_RESET       = 1;

    localparam logic signed [HOLD_W-1:0] HOLD_RESET = {1'b1, {(HOLD_W-1){1'b0}}};

    typedef struct packed {
        logic                valid;
        logic                last;
        logic [PRICE_W-1:0]  price;
        logic [FREE_W-1:0]   free;
        logic [PROFIT_W-1:0] ans;
    } token_t;

endpackage

FILE: hw/rtl/mptk_cell.sv
// One cell of the chain: holding and free balances for one transaction count.
// Depends on mptk_pkg for widths, reset values and token_t.
module mptk_cell
    import mptk_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   adv,
    input  logic   tap_en,
    input  token_t tok_in,
    output token_t tok_out
);

    logic signed [HOLD_W-1:0] hold_reg;
    logic [FREE_W-1:0]        free_reg;
    logic                     valid_reg;
    logic                     last_reg;
    logic [PRICE_W-1:0]       price_reg;
    logic [FREE_W-1:0]        fwd_free_reg;
    logic [PROFIT_W-1:0]      ans_reg;

    logic signed [HOLD_W-1:0] price_s;
    logic signed [HOLD_W-1:0] buy;
    logic signed [HOLD_W-1:0] hold_next;
    logic signed [HOLD_W-1:0] sell;
    logic signed [HOLD_W-1:0] free_s;
    logic signed [HOLD_W-1:0] free_w;
    logic [FREE_W-1:0]        free_next;
    logic                     take;

    assign take      = adv && tok_in.valid;
    assign price_s   = signed'({{(HOLD_W-PRICE_W){1'b0}}, tok_in.price});
    assign buy       = signed'({1'b0, tok_in.free}) - price_s;
    assign hold_next = (buy > hold_reg) ? buy : hold_reg;
    assign sell      = hold_next + price_s;
    assign free_s    = signed'({1'b0, free_reg});
    assign free_w    = (sell > free_s) ? sell : free_s;
    assign free_next = free_w[FREE_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg  <= HOLD_RESET;
            free_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                valid_reg <= tok_in.valid;
            end
            if (take) begin
                if (tok_in.last) begin
                    hold_reg <= HOLD_RESET;
                    free_reg <= '0;
                end else begin
                    hold_reg <= hold_next;
                    free_reg <= free_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            last_reg     <= tok_in.last;
            price_reg    <= tok_in.price;
            fwd_free_reg <= free_next;
            ans_reg      <= tap_en ? free_next[PROFIT_W-1:0] : tok_in.ans;
        end
    end

    always_comb begin
        tok_out.valid = valid_reg;
        tok_out.last  = last_reg;
        tok_out.price = price_reg;
        tok_out.free  = fwd_free_reg;
        tok_out.ans   = ans_reg;
    end

endmodule

FILE: hw/rtl/max_profit_k_transactions_top.sv
// A price word is registered in each cell of the chain on its way to the chain tail; the profit
// word for a last price is registered once more from the tail before it is shown.
// Throughput: one price word per cycle unless stalled; one cell per transaction count.
// The chain stalls only while a finished profit word waits and another is due.
// Sync active-low reset zeroes free balances, sets hold balances to minimum and k_reg to 1.
// Depends on mptk_pkg and mptk_cell.
module max_profit_k_transactions_top
    import mptk_pkg::*;
#(
    parameter int MAX_TRANS = MAX_TRANS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [PRICE_W-1:0]  s_price,
    input  logic                s_last,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [PROFIT_W-1:0] m_profit,
    input  logic                cfg_wr_en,
    input  logic [K_W-1:0]      cfg_wr_data
);

    logic [K_W-1:0]      k_reg;
    logic                m_valid_reg;
    logic [PROFIT_W-1:0] m_profit_reg;
    logic                adv;
    logic                tail_done;
    token_t              tok [MAX_TRANS+1];
    token_t              tail;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= K_W'(K_RESET);
        end else if (cfg_wr_en) begin
            k_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        tok[0]       = '0;
        tok[0].valid = s_valid;
        tok[0].last  = s_last;
        tok[0].price = s_price;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_TRANS; g++) begin : g_cell
            logic tap;
            assign tap = (32'(k_reg) == g + 1) ||
                         ((g == MAX_TRANS - 1) && (32'(k_reg) > MAX_TRANS));
            mptk_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .adv     (adv),
                .tap_en  (tap),
                .tok_in  (tok[g]),
                .tok_out (tok[g+1])
            );
        end
    endgenerate

    assign tail      = tok[MAX_TRANS];
    assign tail_done = tail.valid && tail.last;
    assign adv       = !(tail_done && m_valid_reg && !m_ready);
    assign s_ready   = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv && tail_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && tail_done) begin
            m_profit_reg <= tail.ans;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_profit = m_profit_reg;

    a_stall_holds_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(tail.valid) && $stable(tail.ans))
        else $error("Chain tail changed while stalled.");

    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(tail_done))
        else $error("Profit word shown without a last price at the tail.");

    a_profit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (32'(m_profit_reg) <= MAX_TRANS * 65535))
        else $error("Profit word exceeds its bound.");

endmodule
